// File: rtl/sgs_pkg.sv
// Shared types and constants of the sparse Gauss-Seidel smoother.
package sgs_pkg;

    // Input item op codes
    localparam logic [2:0] OP_LOAD_ENTRY = 3'd0;
    localparam logic [2:0] OP_LOAD_RHS   = 3'd1;
    localparam logic [2:0] OP_LOAD_SOL   = 3'd2;
    localparam logic [2:0] OP_RUN        = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    // Result kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ROW_COUNT  = 3'd0;
    localparam logic [2:0] CFG_NUM_SWEEPS = 3'd1;
    localparam logic [2:0] CFG_WEIGHT0    = 3'd2;
    localparam logic [2:0] CFG_WEIGHT1    = 3'd3;
    localparam logic [2:0] CFG_WEIGHT2    = 3'd4;
    localparam logic [2:0] CFG_WEIGHT3    = 3'd5;

    localparam logic [2:0]  MAX_SWEEPS = 3'd4;
    localparam logic [17:0] WEIGHT_ONE = 18'd65536;
    localparam int          DIV_BITS   = 64;

    typedef enum logic [4:0] {
        DP_IDLE,
        DP_CLEAR,
        DP_ACCEPT,
        DP_RUN_INIT,
        DP_ROW_RD,
        DP_ROW_EVAL,
        DP_E_RD,
        DP_E_COL,
        DP_E_MUL,
        DP_E_ACC,
        DP_DIV_START,
        DP_DIV_WAIT,
        DP_STEP1,
        DP_STEP2,
        DP_WB,
        DP_ROW_NEXT,
        DP_OUT_READ,
        DP_OUT_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic run_empty;
        logic row_has;
        logic k_last;
        logic diag_zero;
        logic div_done;
        logic run_last;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/sparse_gauss_seidel_smoother_top.sv
// Top level of the sparse weighted Gauss-Seidel smoother: ports, configuration registers.
//
// Usage:
//   s_* stream carries items: load matrix entry, load rhs, load solution, run, read.
//   m_* stream returns results: a solution value (m_tuser 0) or a finish mark (m_tuser 1).
//   cfg_* writes the six configuration registers; write only while the block is idle.
// Item handling:
//   Load items are taken one per cycle, back to back.
//   A read item reads the solution memory on acceptance; its value enters the result
//   register once that register is free, and the next item is taken after that.
//   A run item makes every sweep over every row: a row-start read, then for each entry
//   a read, column fetch, multiply and accumulate, then for a nonzero diagonal the
//   64-step bit-serial divider, the weighted step and the writeback.
//   No new item is taken while a run or read is in progress.
// Reset:
//   aresetn low clears the entry count and the result valid flag; a clearing pass then
//   zeroes the row-start memory, during which s_tready stays low (cfg writes still taken).
// Stalls:
//   A result waits in the output register while m_tready is low; loads keep flowing,
//   and a later read result or run finish mark waits until the register is free.
module sparse_gauss_seidel_smoother_top #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // op[2:0], row[12:3], column[22:13], value[54:23]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_row[9:0], out_value[41:10]
    output logic        m_tuser,   // kind
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    sgs_pkg::cmd_t  cmd;
    sgs_pkg::stat_t stat;

    logic [10:0]       row_count_reg;
    logic [2:0]        num_sweeps_reg;
    logic [3:0][17:0]  weights_reg;
    logic [9:0]        m_row;
    logic signed [31:0] m_value;

    // Configuration registers; cfg_ready is held high
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= 11'd1;
            num_sweeps_reg <= 3'd1;
            weights_reg    <= {4{sgs_pkg::WEIGHT_ONE}};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sgs_pkg::CFG_ROW_COUNT:  row_count_reg  <= cfg_data[10:0];
                sgs_pkg::CFG_NUM_SWEEPS: num_sweeps_reg <= cfg_data[2:0];
                sgs_pkg::CFG_WEIGHT0:    weights_reg[0] <= cfg_data;
                sgs_pkg::CFG_WEIGHT1:    weights_reg[1] <= cfg_data;
                sgs_pkg::CFG_WEIGHT2:    weights_reg[2] <= cfg_data;
                sgs_pkg::CFG_WEIGHT3:    weights_reg[3] <= cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    sgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tdata[2:0]),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sgs_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[2:0]),
        .in_row     (s_tdata[12:3]),
        .in_column  (s_tdata[22:13]),
        .in_value   ($signed(s_tdata[54:23])),
        .row_count  (row_count_reg),
        .num_sweeps (num_sweeps_reg),
        .weights    (weights_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_kind     (m_tuser),
        .m_row      (m_row),
        .m_value    (m_value)
    );

    // Pack the result: row lowest, value above, zero fill to whole bytes
    assign m_tdata = {6'b0, m_value, m_row};

endmodule

// File: rtl/sgs_div.sv
// Restoring divider, one quotient bit per cycle, unsigned 64 by 32.
module sgs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sgs_pkg::DIV_BITS-1:0]  dividend,
    input  logic [31:0]                   divisor,
    output logic                          done,
    output logic [sgs_pkg::DIV_BITS-1:0]  quotient
);

    localparam int CNW = $clog2(sgs_pkg::DIV_BITS + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNW-1:0]               cnt_reg;
    logic [sgs_pkg::DIV_BITS-1:0] quo_reg;
    logic [31:0]                  rem_reg;
    logic [31:0]                  dsr_reg;
    logic [32:0]                  shifted;
    logic                         fits;

    assign shifted = {rem_reg, quo_reg[sgs_pkg::DIV_BITS-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(sgs_pkg::DIV_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[sgs_pkg::DIV_BITS-2:0], fits};
            rem_reg <= fits ? 32'(shifted - {1'b0, dsr_reg}) : shifted[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == CNW'(1) && !start |=> done) else $error("divider lost done");
`endif

endmodule

// File: rtl/sgs_datapath.sv
// Datapath: matrix, vector and row-start memories, accumulator, step math, result register.
module sgs_datapath #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sgs_pkg::cmd_t        cmd,
    output sgs_pkg::stat_t       stat,
    input  logic [2:0]           in_op,
    input  logic [9:0]           in_row,
    input  logic [9:0]           in_column,
    input  logic signed [31:0]   in_value,
    input  logic [10:0]          row_count,
    input  logic [2:0]           num_sweeps,
    input  logic [3:0][17:0]     weights,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic                 m_kind,
    output logic [9:0]           m_row,
    output logic signed [31:0]   m_value
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = $clog2(MAX_ROWS + 1);
    localparam logic [36:0] STEP_CLAMP = 37'h10_0000_0000;

    // Memories
    logic signed [31:0] ent_val_mem [MAX_ENTRIES];
    logic [9:0]         ent_col_mem [MAX_ENTRIES];
    logic [CW-1:0]      rstart_mem  [MAX_ROWS];
    logic signed [31:0] rhs_mem     [MAX_ROWS];
    logic signed [31:0] sol_mem     [MAX_ROWS];

    logic signed [31:0] ent_val_rd;
    logic [9:0]         ent_col_rd;
    logic [CW-1:0]      rstart_rd;
    logic signed [31:0] rhs_rd;
    logic signed [31:0] sol_rd;

    // Control registers
    logic [CW-1:0] ecount_reg;
    logic [RW-1:0] clr_reg;
    logic          m_valid_reg;

    // Sweep registers
    logic [1:0]         s_reg;
    logic [RW-1:0]      i_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      end_reg;
    logic [CW-1:0]      k_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] aval_reg;
    logic signed [31:0] diag_reg;
    logic signed [31:0] sol_i_reg;
    logic               colok_reg;
    logic signed [63:0] prod_reg;
    logic               neg_reg;
    logic [49:0]        hi_reg;
    logic [49:0]        lo_reg;
    logic [36:0]        step_reg;
    logic [9:0]         rdrow_reg;
    logic               rdok_reg;
    logic               m_kind_reg;
    logic [9:0]         m_row_reg;
    logic signed [31:0] m_value_reg;

    logic               accept;
    logic               row_ok;
    logic               load_ent;
    logic [RW-1:0]      row_a;
    logic [NW-1:0]      rows_c;
    logic [2:0]         sweeps_c;
    logic [CW-1:0]      end_c;
    logic [17:0]        w_sel;
    logic [RW-1:0]      sol_raddr;
    logic               sol_we;
    logic [RW-1:0]      sol_waddr;
    logic signed [31:0] sol_wdata;
    logic signed [64:0] diff;
    logic signed [63:0] acc_sat;
    logic [63:0]        acc_mag;
    logic [31:0]        diag_mag;
    logic               div_start;
    logic               div_done;
    logic [63:0]        quo;
    logic [36:0]        step_sum;
    logic signed [38:0] next_wide;
    logic signed [31:0] next_sat;
    logic               out_free;
    logic               out_load;

    assign accept   = cmd.op == sgs_pkg::DP_ACCEPT;
    assign row_ok   = 32'(in_row) < MAX_ROWS;
    assign row_a    = RW'(in_row);
    assign load_ent = accept && in_op == sgs_pkg::OP_LOAD_ENTRY && row_ok
                      && 32'(ecount_reg) < MAX_ENTRIES;
    assign rows_c   = (32'(row_count) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(row_count);
    assign sweeps_c = (num_sweeps > sgs_pkg::MAX_SWEEPS) ? sgs_pkg::MAX_SWEEPS : num_sweeps;
    assign w_sel    = weights[s_reg];

    // Clamp the span end into [pos, entry count]
    always_comb begin
        end_c = rstart_rd;
        if (end_c > ecount_reg) begin
            end_c = ecount_reg;
        end
        if (end_c < pos_reg) begin
            end_c = pos_reg;
        end
    end

    // Entry memory
    always_ff @(posedge aclk) begin
        if (load_ent) begin
            ent_val_mem[ecount_reg[EW-1:0]] <= in_value;
            ent_col_mem[ecount_reg[EW-1:0]] <= in_column;
        end
        ent_val_rd <= ent_val_mem[k_reg[EW-1:0]];
        ent_col_rd <= ent_col_mem[k_reg[EW-1:0]];
    end

    // Row start memory, entry r holds the count just after row r
    always_ff @(posedge aclk) begin
        if (cmd.op == sgs_pkg::DP_CLEAR) begin
            rstart_mem[clr_reg] <= '0;
        end else if (load_ent) begin
            rstart_mem[row_a] <= ecount_reg + CW'(1);
        end
        rstart_rd <= rstart_mem[i_reg];
    end

    // Right-hand side memory
    always_ff @(posedge aclk) begin
        if (accept && in_op == sgs_pkg::OP_LOAD_RHS && row_ok) begin
            rhs_mem[row_a] <= in_value;
        end
        rhs_rd <= rhs_mem[i_reg];
    end

    // Solution memory
    always_comb begin
        case (cmd.op)
            sgs_pkg::DP_E_COL:    sol_raddr = RW'(ent_col_rd);
            sgs_pkg::DP_ACCEPT:   sol_raddr = row_a;
            sgs_pkg::DP_OUT_READ: sol_raddr = RW'(rdrow_reg);
            default:              sol_raddr = i_reg;
        endcase
        sol_we    = (cmd.op == sgs_pkg::DP_WB)
                    || (accept && in_op == sgs_pkg::OP_LOAD_SOL && row_ok);
        sol_waddr = (cmd.op == sgs_pkg::DP_WB) ? i_reg : row_a;
        sol_wdata = (cmd.op == sgs_pkg::DP_WB) ? next_sat : in_value;
    end

    always_ff @(posedge aclk) begin
        if (sol_we) begin
            sol_mem[sol_waddr] <= sol_wdata;
        end
        sol_rd <= sol_mem[sol_raddr];
    end

    // Saturating accumulate
    assign diff    = {acc_reg[63], acc_reg} - {prod_reg[63], prod_reg};
    assign acc_sat = (diff[64] != diff[63])
                     ? (diff[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                     : diff[63:0];

    assign acc_mag   = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign diag_mag  = diag_reg[31] ? (32'd0 - diag_reg) : diag_reg;
    assign div_start = cmd.op == sgs_pkg::DP_DIV_START && diag_reg != 32'sd0;

    sgs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (diag_mag),
        .done     (div_done),
        .quotient (quo)
    );

    // Weighted step: take the magnitude in Q16.16, clamp at 2^36
    assign step_sum  = {1'b0, hi_reg[19:0], 16'b0} + {3'b0, lo_reg[49:16]};
    assign next_wide = neg_reg ? (39'(sol_i_reg) - $signed({2'b0, step_reg}))
                               : (39'(sol_i_reg) + $signed({2'b0, step_reg}));
    always_comb begin
        if (next_wide > 39'sd2147483647) begin
            next_sat = 32'sh7FFF_FFFF;
        end else if (next_wide < -39'sd2147483648) begin
            next_sat = 32'sh8000_0000;
        end else begin
            next_sat = next_wide[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            sgs_pkg::DP_ACCEPT: begin
                rdrow_reg <= in_row;
                rdok_reg  <= row_ok;
            end
            sgs_pkg::DP_RUN_INIT: begin
                s_reg   <= '0;
                i_reg   <= '0;
                pos_reg <= '0;
            end
            sgs_pkg::DP_ROW_EVAL: begin
                end_reg   <= end_c;
                k_reg     <= pos_reg;
                acc_reg   <= {{16{rhs_rd[31]}}, rhs_rd, 16'b0};
                sol_i_reg <= sol_rd;
            end
            sgs_pkg::DP_E_COL: begin
                aval_reg  <= ent_val_rd;
                colok_reg <= 32'(ent_col_rd) < MAX_ROWS;
                if (k_reg == pos_reg) begin
                    diag_reg <= ent_val_rd;
                end
            end
            sgs_pkg::DP_E_MUL: begin
                prod_reg <= aval_reg * (colok_reg ? sol_rd : 32'sd0);
            end
            sgs_pkg::DP_E_ACC: begin
                acc_reg <= acc_sat;
                k_reg   <= k_reg + CW'(1);
            end
            sgs_pkg::DP_DIV_START: begin
                neg_reg <= acc_reg[63] ^ diag_reg[31];
            end
            sgs_pkg::DP_STEP1: begin
                hi_reg <= quo[63:32] * w_sel;
                lo_reg <= quo[31:0] * w_sel;
            end
            sgs_pkg::DP_STEP2: begin
                if (hi_reg >= 50'd1048576 || step_sum > STEP_CLAMP) begin
                    step_reg <= STEP_CLAMP;
                end else begin
                    step_reg <= step_sum;
                end
            end
            sgs_pkg::DP_ROW_NEXT: begin
                if (stat.run_last || NW'(i_reg) + NW'(1) == rows_c) begin
                    i_reg   <= '0;
                    pos_reg <= '0;
                    s_reg   <= s_reg + 2'd1;
                end else begin
                    i_reg   <= i_reg + RW'(1);
                    pos_reg <= end_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && (cmd.op == sgs_pkg::DP_OUT_READ
                                   || cmd.op == sgs_pkg::DP_OUT_FIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ecount_reg  <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_ent) begin
                ecount_reg <= ecount_reg + CW'(1);
            end
            if (cmd.op == sgs_pkg::DP_CLEAR) begin
                clr_reg <= clr_reg + RW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (cmd.op == sgs_pkg::DP_OUT_READ) begin
                m_kind_reg  <= sgs_pkg::KIND_VALUE;
                m_row_reg   <= rdrow_reg;
                m_value_reg <= rdok_reg ? sol_rd : 32'sd0;
            end else begin
                m_kind_reg  <= sgs_pkg::KIND_FINISH;
                m_row_reg   <= '0;
                m_value_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_row    = m_row_reg;
    assign m_value  = m_value_reg;

    assign stat.clr_last  = clr_reg == RW'(MAX_ROWS - 1);
    assign stat.run_empty = rows_c == '0 || sweeps_c == 3'd0;
    assign stat.row_has   = end_c > pos_reg;
    assign stat.k_last    = k_reg + CW'(1) == end_reg;
    assign stat.diag_zero = diag_reg == 32'sd0;
    assign stat.div_done  = div_done;
    assign stat.run_last  = NW'(i_reg) + NW'(1) == rows_c
                            && 3'(s_reg) + 3'd1 == sweeps_c;
    assign stat.out_free  = out_free;

`ifndef ASSERT_OFF
    a_k_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == sgs_pkg::DP_E_ACC |-> k_reg < end_reg) else $error("entry index past span");
    a_ecount_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load_ent |=> ecount_reg == $past(ecount_reg) + CW'(1)) else $error("entry count slip");
    a_wb_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == sgs_pkg::DP_WB |-> diag_reg != 32'sd0) else $error("writeback on zero diagonal");
`endif

endmodule

// File: rtl/sgs_ctrl.sv
// Controller state machine: sequences clearing, loads, reads and relaxation sweeps.
module sgs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic [2:0]     in_op,
    output logic           s_tready,
    output sgs_pkg::cmd_t  cmd,
    input  sgs_pkg::stat_t stat
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN_INIT,
        ST_ROW_RD,
        ST_ROW_EVAL,
        ST_E_RD,
        ST_E_COL,
        ST_E_MUL,
        ST_E_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_STEP1,
        ST_STEP2,
        ST_WB,
        ST_ROW_NEXT,
        ST_OUT_READ,
        ST_OUT_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = sgs_pkg::DP_IDLE;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = sgs_pkg::DP_CLEAR;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = sgs_pkg::DP_ACCEPT;
                    if (in_op == sgs_pkg::OP_RUN) begin
                        state_next = ST_RUN_INIT;
                    end else if (in_op == sgs_pkg::OP_READ) begin
                        state_next = ST_OUT_READ;
                    end
                end
            end
            ST_RUN_INIT: begin
                cmd.op     = sgs_pkg::DP_RUN_INIT;
                state_next = stat.run_empty ? ST_OUT_FIN : ST_ROW_RD;
            end
            ST_ROW_RD: begin
                cmd.op     = sgs_pkg::DP_ROW_RD;
                state_next = ST_ROW_EVAL;
            end
            ST_ROW_EVAL: begin
                cmd.op     = sgs_pkg::DP_ROW_EVAL;
                state_next = stat.row_has ? ST_E_RD : ST_ROW_NEXT;
            end
            ST_E_RD: begin
                cmd.op     = sgs_pkg::DP_E_RD;
                state_next = ST_E_COL;
            end
            ST_E_COL: begin
                cmd.op     = sgs_pkg::DP_E_COL;
                state_next = ST_E_MUL;
            end
            ST_E_MUL: begin
                cmd.op     = sgs_pkg::DP_E_MUL;
                state_next = ST_E_ACC;
            end
            ST_E_ACC: begin
                cmd.op     = sgs_pkg::DP_E_ACC;
                state_next = stat.k_last ? ST_DIV_START : ST_E_RD;
            end
            ST_DIV_START: begin
                cmd.op     = sgs_pkg::DP_DIV_START;
                state_next = stat.diag_zero ? ST_ROW_NEXT : ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                cmd.op = sgs_pkg::DP_DIV_WAIT;
                if (stat.div_done) begin
                    state_next = ST_STEP1;
                end
            end
            ST_STEP1: begin
                cmd.op     = sgs_pkg::DP_STEP1;
                state_next = ST_STEP2;
            end
            ST_STEP2: begin
                cmd.op     = sgs_pkg::DP_STEP2;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.op     = sgs_pkg::DP_WB;
                state_next = ST_ROW_NEXT;
            end
            ST_ROW_NEXT: begin
                cmd.op     = sgs_pkg::DP_ROW_NEXT;
                state_next = stat.run_last ? ST_OUT_FIN : ST_ROW_RD;
            end
            ST_OUT_READ: begin
                cmd.op = sgs_pkg::DP_OUT_READ;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT_FIN: begin
                cmd.op = sgs_pkg::DP_OUT_FIN;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule
